// ===== rtl/core/tbd_pkg.sv =====
// Shared types and constants for the two-button debouncer with long-press detection.
// Used by the channel interfaces, the per-button unit and the top level.
package tbd_pkg;

  localparam int PollStepWidth    = 8;
  localparam int LongPressWidth   = 16;
  localparam int DebounceWidth    = 4;
  localparam int HoldWidthDefault = 16;

  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 16;

  localparam logic [PollStepWidth-1:0]  PollStepReset  = 8'd30;
  localparam logic [LongPressWidth-1:0] LongPressReset = 16'd1000;
  localparam logic [DebounceWidth-1:0]  DebounceReset  = 4'd3;

  localparam logic [CfgIndexWidth-1:0] RegPollStep  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegLongPress = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegDebounce  = 2'd2;

  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_SHORT = 2'd1,
    EVT_LONG  = 2'd2
  } event_t;

  typedef struct packed {
    logic [PollStepWidth-1:0]  poll_step_ms;
    logic [LongPressWidth-1:0] long_limit_ms;
    logic [DebounceWidth-1:0]  debounce_samples;
  } cfg_t;

endpackage

// ===== rtl/core/tbd_channels_if.sv =====
// Valid/ready channel interfaces for the debouncer: poll samples, events, register writes.
// Depends on tbd_pkg for field widths.
interface tbd_sample_if;
  logic valid;
  logic ready;
  logic key_raw;
  logic boot_raw;

  modport source (output valid, key_raw, boot_raw, input ready);
  modport sink (input valid, key_raw, boot_raw, output ready);
endinterface

interface tbd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] key_event;
  logic [1:0] boot_event;

  modport source (output valid, key_event, boot_event, input ready);
  modport sink (input valid, key_event, boot_event, output ready);
endinterface

interface tbd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tbd_pkg::CfgIndexWidth-1:0] index;
  logic [tbd_pkg::CfgDataWidth-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/two_button_debounce_long_press.sv =====
// Top level of the two-button debouncer with short and long press events.
// Depends on tbd_pkg, the channel interfaces in tbd_channels_if and tbd_button.
//
//   channel  | dir | transaction carries
//   ---------+-----+--------------------------------------------
//   sample   | in  | key_raw, boot_raw: one poll tick
//   result   | out | key_event, boot_event: one per poll tick
//   cfg      | in  | index, data: register write, always ready
//
// One poll tick is taken per clock while sample.ready is high; its events are
// registered in the head entry, or in the skid entry while the head is held.
// Reset (rst, synchronous) clears all button state and loads register defaults.
// A two-entry output buffer keeps sample.ready high while the result side stalls
// until the skid entry fills; ready drops only while both entries are full.
module two_button_debounce_long_press #(
  parameter int HOLD_WIDTH = tbd_pkg::HoldWidthDefault
) (
  input logic          clk,
  input logic          rst,
  tbd_sample_if.sink   sample,
  tbd_result_if.source result,
  tbd_cfg_if.sink      cfg
);

  // Configuration registers.
  tbd_pkg::cfg_t cfg_regs;

  // Output buffer: head entry drives the port, skid entry catches one more.
  logic            out_valid;
  tbd_pkg::event_t out_key;
  tbd_pkg::event_t out_boot;
  logic            skid_valid;
  tbd_pkg::event_t skid_key;
  tbd_pkg::event_t skid_boot;

  logic            accept;
  logic            pop;
  tbd_pkg::event_t key_evt;
  tbd_pkg::event_t boot_evt;

  assign cfg.ready = 1'b1;

  // Write the addressed register; drop writes beyond the register list.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.poll_step_ms     <= tbd_pkg::PollStepReset;
      cfg_regs.long_limit_ms    <= tbd_pkg::LongPressReset;
      cfg_regs.debounce_samples <= tbd_pkg::DebounceReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        tbd_pkg::RegPollStep: begin
          cfg_regs.poll_step_ms <= cfg.data[tbd_pkg::PollStepWidth-1:0];
        end
        tbd_pkg::RegLongPress: begin
          cfg_regs.long_limit_ms <= cfg.data[tbd_pkg::LongPressWidth-1:0];
        end
        tbd_pkg::RegDebounce: begin
          cfg_regs.debounce_samples <= cfg.data[tbd_pkg::DebounceWidth-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Accept a sample whenever the skid entry is free.
  assign sample.ready = !skid_valid;
  assign accept       = sample.valid && sample.ready;
  assign pop          = out_valid && result.ready;

  // Each button advances its state only on an accepted sample.
  tbd_button #(
    .HOLD_WIDTH (HOLD_WIDTH)
  ) u_key (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .raw     (sample.key_raw),
    .cfg     (cfg_regs),
    .evt     (key_evt)
  );

  tbd_button #(
    .HOLD_WIDTH (HOLD_WIDTH)
  ) u_boot (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .raw     (sample.boot_raw),
    .cfg     (cfg_regs),
    .evt     (boot_evt)
  );

  // Output buffer control: refill the head from the skid entry first, to keep order.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  // Payload of the buffer entries; no reset needed.
  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_key  <= skid_key;
      out_boot <= skid_boot;
    end else if (accept && (pop || !out_valid)) begin
      out_key  <= key_evt;
      out_boot <= boot_evt;
    end
    if (accept && out_valid && !pop) begin
      skid_key  <= key_evt;
      skid_boot <= boot_evt;
    end
  end

  assign result.valid      = out_valid;
  assign result.key_event  = out_key;
  assign result.boot_event = out_boot;

endmodule

// ===== rtl/core/tbd_button.sv =====
// Debounce and press-length tracking for one button.
// Depends on tbd_pkg for the config struct and the event codes.
module tbd_button #(
  parameter int HOLD_WIDTH = tbd_pkg::HoldWidthDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            raw,
  input  tbd_pkg::cfg_t   cfg,
  output tbd_pkg::event_t evt
);

  localparam int CmpWidth = (HOLD_WIDTH > tbd_pkg::LongPressWidth) ?
                            HOLD_WIDTH : tbd_pkg::LongPressWidth;

  logic                              last_raw, last_raw_next;
  logic [tbd_pkg::DebounceWidth-1:0] stable_count, stable_count_next;
  logic                              debounced, debounced_next;
  logic [HOLD_WIDTH-1:0]             hold_time, hold_time_next;
  logic                              long_done, long_done_next;

  logic [tbd_pkg::DebounceWidth-1:0] thr;
  logic                              flipped;
  logic [HOLD_WIDTH:0]               hold_sum;
  logic [HOLD_WIDTH-1:0]             hold_sat;

  always_comb begin
    thr = (cfg.debounce_samples == '0) ? tbd_pkg::DebounceWidth'(1) : cfg.debounce_samples;
    last_raw_next     = last_raw;
    stable_count_next = stable_count;
    flipped           = 1'b0;
    if (raw != last_raw) begin
      last_raw_next     = raw;
      stable_count_next = tbd_pkg::DebounceWidth'(1);
    end else begin
      stable_count_next = (stable_count < thr) ? stable_count + 1'b1 : thr;
      flipped           = (stable_count_next >= thr) && (debounced != raw);
    end
    debounced_next = flipped ? raw : debounced;

    // Saturate the hold time at its all-ones value.
    hold_sum = {1'b0, hold_time}
             + {{(HOLD_WIDTH + 1 - tbd_pkg::PollStepWidth){1'b0}}, cfg.poll_step_ms};
    hold_sat = hold_sum[HOLD_WIDTH] ? '1 : hold_sum[HOLD_WIDTH-1:0];

    hold_time_next = hold_time;
    long_done_next = long_done;
    evt            = tbd_pkg::EVT_NONE;
    if (debounced_next) begin
      hold_time_next = hold_sat;
      if (!long_done && (CmpWidth'(hold_sat) >= CmpWidth'(cfg.long_limit_ms))) begin
        long_done_next = 1'b1;
        evt            = tbd_pkg::EVT_LONG;
      end
    end else if (flipped) begin
      evt            = long_done ? tbd_pkg::EVT_NONE : tbd_pkg::EVT_SHORT;
      hold_time_next = '0;
      long_done_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw     <= 1'b0;
      stable_count <= '0;
      debounced    <= 1'b0;
      hold_time    <= '0;
      long_done    <= 1'b0;
    end else if (advance) begin
      last_raw     <= last_raw_next;
      stable_count <= stable_count_next;
      debounced    <= debounced_next;
      hold_time    <= hold_time_next;
      long_done    <= long_done_next;
    end
  end

endmodule
